// ===== rtl/stbs_pkg.sv =====
// Package for the sorted table binary search core: sizes, codes, payload types.
// No dependencies; used by the core and its RAM instance by scoped names.
`default_nettype none

package stbs_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int KEY_WIDTH   = 32;
	localparam int ADDR_WIDTH  = $clog2(TABLE_DEPTH);
	localparam int POS_WIDTH   = ADDR_WIDTH + 1;
	localparam int CFG_WIDTH   = 9;
	localparam int CFG_IDX_W   = 1;

	localparam logic [POS_WIDTH-1:0] TABLE_SIZE = POS_WIDTH'(TABLE_DEPTH);

	// Operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED_KEYS = 1'd1;

	typedef struct packed {
		logic                  operation;
		logic [ADDR_WIDTH-1:0] entry_index;
		logic [KEY_WIDTH-1:0]  key;
	} req_t;

	typedef struct packed {
		logic                 found;
		logic [POS_WIDTH-1:0] position;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_PROBE = 3'b010,
		ST_DONE  = 3'b100
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/stbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
`default_nettype none

module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_table_binary_search_core.sv =====
// Sorted table binary search core: key table in RAM, search sequencer, result register.
// Depends on stbs_pkg and stbs_ram.
`default_nettype none

// Usage
//  - req channel (valid/ready) carries write and search items. A write item stores
//    req.key at req.entry_index in the key table and produces no response. A search
//    item produces exactly one response on the rsp channel.
//  - cfg port: cfg_we with cfg_index selects entry_count (number of entries searched,
//    clamped to the table depth) or signed_keys (bit 0: compare as two's complement).
//    Write it only while the core is idle.
//  - Write items transfer at one per cycle while the core is idle.
//  - A search makes one probe per cycle: the table RAM has one read port with a
//    registered read, and the compare of each probe picks the next probe address in
//    the same cycle. With n entries a search makes at most ceil(log2(n+1)) probes
//    (nine for 256 entries). After the last probe the result passes to the output
//    register once it is free, which raises rsp_valid; the next item can be taken in
//    the same cycle that rsp_valid rises.
//  - The response sits in an output register; the core takes new items while it
//    waits. If the receiver stalls and a second result is ready, the sequencer holds
//    that result until the register frees.
//  - Reset clears cfg, sequencer state and rsp_valid, not datapath or rsp data;
//    the table content is undefined until written and needs no clearing pass.
module sorted_table_binary_search_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  req_valid,
	output logic                                 req_ready,
	input  wire stbs_pkg::req_t                  req,
	output logic                                 rsp_valid,
	input  wire                                  rsp_ready,
	output stbs_pkg::rsp_t                       rsp,
	input  wire                                  cfg_we,
	input  wire [stbs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [stbs_pkg::CFG_WIDTH-1:0]        cfg_data
);

	localparam int AW = stbs_pkg::ADDR_WIDTH;
	localparam int PW = stbs_pkg::POS_WIDTH;
	localparam int KW = stbs_pkg::KEY_WIDTH;

	stbs_pkg::state_t state_q;

	logic [PW-1:0] entry_count_q;
	logic          signed_keys_q;

	logic [PW-1:0] low_q;
	logic [PW-1:0] high_q;
	logic [PW-1:0] mid_q;
	logic [KW-1:0] key_q;
	stbs_pkg::rsp_t res_q;

	logic          rsp_valid_q;
	stbs_pkg::rsp_t rsp_q;

	logic          req_fire;
	logic          do_write;
	logic          do_start;
	logic [PW-1:0] span;
	logic [KW-1:0] rdata;
	logic [KW-1:0] cmp_a;
	logic [KW-1:0] cmp_b;
	logic [KW-1:0] sign_flip;
	logic          key_eq;
	logic          key_gt;
	logic [PW-1:0] mid_p1;
	logic [PW-1:0] up_mid;
	logic [PW-1:0] dn_mid;
	logic          up_end;
	logic          dn_end;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          out_free;

	assign req_ready = (state_q == stbs_pkg::ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign do_write  = req_fire && (req.operation == stbs_pkg::OP_WRITE);
	assign do_start  = req_fire && (req.operation == stbs_pkg::OP_SEARCH);

	// Clamp the searched range to the table depth.
	assign span = (entry_count_q > stbs_pkg::TABLE_SIZE) ? stbs_pkg::TABLE_SIZE
		: entry_count_q;

	// Signed order equals unsigned order once both sign bits are inverted.
	assign sign_flip = {signed_keys_q, {(KW-1){1'b0}}};
	assign cmp_a     = key_q ^ sign_flip;
	assign cmp_b     = rdata ^ sign_flip;
	assign key_eq    = (cmp_a == cmp_b);
	assign key_gt    = (cmp_a > cmp_b);

	// Both candidate next probes are formed beside the compare; the compare only selects.
	assign mid_p1 = mid_q + PW'(1);
	assign up_mid = mid_p1 + ((high_q - mid_p1) >> 1);
	assign dn_mid = low_q + ((mid_q - low_q) >> 1);
	assign up_end = (mid_p1 == high_q);
	assign dn_end = (low_q == mid_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				rd_en   = do_start;
				rd_addr = span[AW:1];
			end
			stbs_pkg::ST_PROBE: begin
				rd_en   = !key_eq;
				rd_addr = key_gt ? up_mid[AW-1:0] : dn_mid[AW-1:0];
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	stbs_ram #(
		.WIDTH(KW),
		.DEPTH(stbs_pkg::TABLE_DEPTH)
	) u_key_table (
		.clk   (clk),
		.we    (do_write),
		.waddr (req.entry_index),
		.wdata (req.key),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			signed_keys_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				stbs_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data[PW-1:0];
				stbs_pkg::REG_SIGNED_KEYS: signed_keys_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stbs_pkg::ST_IDLE;
		end else begin
			case (state_q)
				stbs_pkg::ST_IDLE: begin
					if (do_start) begin
						state_q <= (span == '0) ? stbs_pkg::ST_DONE : stbs_pkg::ST_PROBE;
					end
				end
				stbs_pkg::ST_PROBE: begin
					if (key_eq || (key_gt && up_end) || (!key_gt && dn_end)) begin
						state_q <= stbs_pkg::ST_DONE;
					end
				end
				stbs_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= stbs_pkg::ST_IDLE;
					end
				end
				default: state_q <= stbs_pkg::ST_IDLE;
			endcase
		end
	end

	// Search datapath: bounds, probe index, pending result
	always_ff @(posedge clk) begin
		case (state_q)
			stbs_pkg::ST_IDLE: begin
				if (do_start) begin
					key_q          <= req.key;
					low_q          <= '0;
					high_q         <= span;
					mid_q          <= span >> 1;
					res_q.found    <= 1'b0;
					res_q.position <= '0;
				end
			end
			stbs_pkg::ST_PROBE: begin
				if (key_eq) begin
					res_q.found    <= 1'b1;
					res_q.position <= mid_q;
				end else if (key_gt) begin
					low_q          <= mid_p1;
					mid_q          <= up_mid;
					res_q.found    <= 1'b0;
					res_q.position <= mid_p1;
				end else begin
					high_q         <= mid_q;
					mid_q          <= dn_mid;
					res_q.found    <= 1'b0;
					res_q.position <= low_q;
				end
			end
			default: ;
		endcase
	end

	// Output register: free when empty or drained this cycle
	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == stbs_pkg::ST_DONE) && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == stbs_pkg::ST_DONE) && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
